### hw/rtl/timed_pump_dose_controller_assert.svh
// assertion macros shared by the checker
`ifndef TIMED_PUMP_DOSE_CONTROLLER_ASSERT_SVH
`define TIMED_PUMP_DOSE_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TPDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tpdc_pkg.sv
package tpdc_pkg;

	localparam int DUR_W    = 26;
	localparam int KICK_W   = 16;
	localparam int SINCE_W  = 14;
	localparam int FLOW_W   = 16;
	localparam int DOSE_W   = 14;
	localparam int MOIST_W  = 7;
	localparam int NUM_W    = 32;
	localparam int MUL_W    = 16;
	localparam int CFG_W    = 16;

	localparam logic [KICK_W-1:0]  KICK_TICKS     = 16'd500;
	localparam logic [SINCE_W-1:0] CHECK_INTERVAL = 14'd10000;
	localparam logic [SINCE_W-1:0] CHECK_SAT      = 14'd16383;
	localparam logic [11:0]        DOSE_MAX_Q4    = 12'd2400;
	localparam logic [FLOW_W-1:0]  MS_SCALE       = 16'd16000;
	localparam logic [DUR_W-1:0]   DUR_MAX        = {DUR_W{1'b1}};

	localparam logic [0:0]         RST_AUTO_MODE  = 1'b0;
	localparam logic [FLOW_W-1:0]  RST_FLOW       = 16'd2048;
	localparam logic [MOIST_W-1:0] RST_TARGET     = 7'd30;
	localparam logic [15:0]        RST_AUTO_DUR   = 16'd3000;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	localparam logic [1:0] DRIVE_OFF  = 2'd0;
	localparam logic [1:0] DRIVE_KICK = 2'd1;
	localparam logic [1:0] DRIVE_RUN  = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_BUSY = 2'd1;
	localparam logic [1:0] ERR_ZERO = 2'd2;

	localparam logic [1:0] REG_AUTO_MODE = 2'd0;
	localparam logic [1:0] REG_FLOW      = 2'd1;
	localparam logic [1:0] REG_TARGET    = 2'd2;
	localparam logic [1:0] REG_AUTO_DUR  = 2'd3;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [FLOW_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              busy;
		logic [1:0]        phase;
		logic [DUR_W-1:0]  rem;
		logic [KICK_W-1:0] kick;
		logic [DUR_W-1:0]  dur;
	} dose_t;

	// clamp to 150 mL and scale to the run-time numerator
	function automatic logic [NUM_W-1:0] run_num(input logic [NUM_W-1:0] dose);
		logic [11:0] c;
		c = (dose > NUM_W'(DOSE_MAX_Q4)) ? DOSE_MAX_Q4 : dose[11:0];
		return NUM_W'(c) * NUM_W'(MS_SCALE);
	endfunction

endpackage

### hw/rtl/tpdc_mul.sv
module tpdc_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tpdc_pkg::mul_req_t                  req,
	output logic                                done,
	output logic [2*tpdc_pkg::MUL_W-1:0]        prod
);

	logic                          busy_q;
	logic                          done_q;
	logic [$clog2(tpdc_pkg::MUL_W)-1:0] cnt_q;
	logic [tpdc_pkg::MUL_W-1:0]    a_q;
	logic [tpdc_pkg::MUL_W-1:0]    q_q;
	logic [tpdc_pkg::MUL_W-1:0]    m_q;
	logic [tpdc_pkg::MUL_W:0]      sum;

	// one multiplier bit per cycle, lsb first
	assign sum = {1'b0, a_q} + (q_q[0] ? {1'b0, m_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $bits(cnt_q)'(tpdc_pkg::MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= '0;
			q_q <= req.b;
			m_q <= req.a;
		end else if (busy_q) begin
			a_q <= sum[tpdc_pkg::MUL_W:1];
			q_q <= {sum[0], q_q[tpdc_pkg::MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {a_q, q_q};

endmodule

### hw/rtl/tpdc_div.sv
module tpdc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpdc_pkg::div_req_t            req,
	output logic                          done,
	output logic [tpdc_pkg::NUM_W-1:0]    quot
);

	logic                               busy_q;
	logic                               done_q;
	logic [$clog2(tpdc_pkg::NUM_W)-1:0] cnt_q;
	logic [tpdc_pkg::NUM_W-1:0]         num_q;
	logic [tpdc_pkg::FLOW_W-1:0]        den_q;
	logic [tpdc_pkg::FLOW_W-1:0]        rem_q;
	logic [tpdc_pkg::FLOW_W:0]          trial;
	logic                               qbit;
	logic [tpdc_pkg::FLOW_W-1:0]        rem_nx;

	// restoring division, one quotient bit per cycle, msb first
	// a zero divisor yields all ones
	always_comb begin
		trial  = {rem_q, num_q[tpdc_pkg::NUM_W-1]};
		qbit   = trial >= {1'b0, den_q};
		rem_nx = qbit ? tpdc_pkg::FLOW_W'(trial - {1'b0, den_q})
		              : trial[tpdc_pkg::FLOW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $bits(cnt_q)'(tpdc_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[tpdc_pkg::NUM_W-2:0], qbit};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

### hw/rtl/timed_pump_dose_controller.sv
// Timed pump dosing controller.
// Input channel (in_valid/in_stall) carries one transaction per event: kind
// 0 is a millisecond tick, 1 starts a dose of dose_q4 (Q10.4 mL), 2 stops the
// pump. moisture_percent is sampled on ticks that run an automatic check.
// Output channel (out_valid/out_stall) returns exactly one transaction per
// input with the pump drive, watering flag, done report and error code.
// Ticks with no automatic dose, stops and rejected starts answer in the
// cycle after acceptance. A valid start runs the 32-step bit-serial
// restoring divider that turns the dose into a run time. An automatic dose
// runs the 16-step serial multiplier, then the divider up to twice. One
// transaction is in work at a time; the next is accepted once the result is
// registered and the output register is free or being emptied. A stalled
// result holds in the output register; in_stall stays high while the output
// register is full and stalled. The user must write configuration through
// cfg_we/cfg_idx/cfg_data only while idle; the block does not enforce it.
// Reset clears all dose state and loads the register defaults.
module timed_pump_dose_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_idx,
	input  logic [tpdc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       kind,
	input  logic [tpdc_pkg::DOSE_W-1:0]      dose_q4,
	input  logic [tpdc_pkg::MOIST_W-1:0]     moisture_percent,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       pump_drive,
	output logic                             watering,
	output logic                             done_res,
	output logic [tpdc_pkg::DUR_W-1:0]       done_duration_ms,
	output logic [1:0]                       error
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ADIV = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	state_t                            state_q, state_d;
	logic                              auto_mode_q;
	logic [tpdc_pkg::FLOW_W-1:0]       flow_q;
	logic [tpdc_pkg::MOIST_W-1:0]      target_q;
	logic [15:0]                       auto_dur_q;
	tpdc_pkg::dose_t                   dose_q, dose_d, tick_st, launch_st;
	logic [tpdc_pkg::SINCE_W-1:0]      since_q, since_d, since_inc;
	logic                              from_auto_q, from_auto_d;
	logic                              check;

	logic                              commit;
	logic                              res_done;
	logic [tpdc_pkg::DUR_W-1:0]        res_dur;
	logic [1:0]                        res_err;

	logic                              out_valid_q;
	logic [1:0]                        pump_drive_q;
	logic                              watering_q;
	logic                              done_res_q;
	logic [tpdc_pkg::DUR_W-1:0]        done_dur_q;
	logic [1:0]                        error_q;

	tpdc_pkg::mul_req_t                mul_req;
	logic                              mul_done;
	logic [2*tpdc_pkg::MUL_W-1:0]      mul_prod;
	tpdc_pkg::div_req_t                div_req;
	logic                              div_done;
	logic [tpdc_pkg::NUM_W-1:0]        div_quot;
	logic                              in_acc;

	// end-of-tick phase change and completion
	function automatic tpdc_pkg::dose_t settle(input tpdc_pkg::dose_t s);
		tpdc_pkg::dose_t r;
		r = s;
		if (s.busy) begin
			if (s.phase == tpdc_pkg::DRIVE_KICK && s.kick == '0)
				r.phase = tpdc_pkg::DRIVE_RUN;
			if (s.rem == '0) begin
				r.phase = tpdc_pkg::DRIVE_OFF;
				r.busy  = 1'b0;
				r.kick  = '0;
			end
		end
		return r;
	endfunction

	tpdc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tpdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign in_stall = !(state_q == ST_IDLE && (!out_valid_q || !out_stall));
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		tick_st = dose_q;
		if (dose_q.busy) begin
			if (dose_q.rem != '0)
				tick_st.rem = dose_q.rem - 1'b1;
			if (dose_q.kick != '0)
				tick_st.kick = dose_q.kick - 1'b1;
		end
		since_inc = (since_q < tpdc_pkg::CHECK_SAT) ? since_q + 1'b1 : since_q;
		check     = !dose_q.busy && auto_mode_q && since_inc > tpdc_pkg::CHECK_INTERVAL;

		launch_st.busy  = 1'b1;
		launch_st.phase = tpdc_pkg::DRIVE_KICK;
		launch_st.kick  = tpdc_pkg::KICK_TICKS;
		launch_st.rem   = (div_quot > tpdc_pkg::NUM_W'(tpdc_pkg::DUR_MAX))
		                  ? tpdc_pkg::DUR_MAX : div_quot[tpdc_pkg::DUR_W-1:0];
		launch_st.dur   = launch_st.rem;
	end

	always_comb begin
		state_d     = state_q;
		dose_d      = dose_q;
		since_d     = since_q;
		from_auto_d = from_auto_q;
		commit      = 1'b0;
		res_done    = 1'b0;
		res_dur     = '0;
		res_err     = tpdc_pkg::ERR_NONE;
		mul_req     = '0;
		div_req     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (kind)
						tpdc_pkg::KIND_TICK: begin
							since_d = check ? '0 : since_inc;
							if (check && moisture_percent < target_q) begin
								mul_req.start = 1'b1;
								mul_req.a     = auto_dur_q;
								mul_req.b     = flow_q;
								state_d       = ST_MUL;
							end else begin
								dose_d   = settle(tick_st);
								commit   = 1'b1;
								res_done = tick_st.busy && tick_st.rem == '0;
								res_dur  = res_done ? tick_st.dur : '0;
							end
						end
						tpdc_pkg::KIND_START: begin
							if (dose_q.busy) begin
								commit  = 1'b1;
								res_err = tpdc_pkg::ERR_BUSY;
							end else if (dose_q4 == '0) begin
								commit  = 1'b1;
								res_err = tpdc_pkg::ERR_ZERO;
							end else begin
								div_req.start = 1'b1;
								div_req.num   = tpdc_pkg::run_num(tpdc_pkg::NUM_W'(dose_q4));
								div_req.den   = flow_q;
								from_auto_d   = 1'b0;
								state_d       = ST_DIV;
							end
						end
						tpdc_pkg::KIND_STOP: begin
							dose_d.busy  = 1'b0;
							dose_d.phase = tpdc_pkg::DRIVE_OFF;
							dose_d.rem   = '0;
							dose_d.kick  = '0;
							commit       = 1'b1;
						end
						default: begin
							commit = 1'b1;
						end
					endcase
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					div_req.start = 1'b1;
					div_req.num   = mul_prod;
					div_req.den   = tpdc_pkg::MS_SCALE;
					state_d       = ST_ADIV;
				end
			end
			ST_ADIV: begin
				if (div_done) begin
					if (div_quot == '0) begin
						commit  = 1'b1;
						res_err = tpdc_pkg::ERR_ZERO;
						state_d = ST_IDLE;
					end else begin
						div_req.start = 1'b1;
						div_req.num   = tpdc_pkg::run_num(div_quot);
						div_req.den   = flow_q;
						from_auto_d   = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
					if (from_auto_q) begin
						dose_d   = settle(launch_st);
						res_done = launch_st.rem == '0;
						res_dur  = res_done ? launch_st.dur : '0;
					end else begin
						dose_d = launch_st;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dose_q      <= '0;
			since_q     <= '0;
			from_auto_q <= 1'b0;
			out_valid_q <= 1'b0;
			auto_mode_q <= tpdc_pkg::RST_AUTO_MODE;
			flow_q      <= tpdc_pkg::RST_FLOW;
			target_q    <= tpdc_pkg::RST_TARGET;
			auto_dur_q  <= tpdc_pkg::RST_AUTO_DUR;
		end else begin
			state_q     <= state_d;
			dose_q      <= dose_d;
			since_q     <= since_d;
			from_auto_q <= from_auto_d;
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					tpdc_pkg::REG_AUTO_MODE: auto_mode_q <= cfg_data[0];
					tpdc_pkg::REG_FLOW:      flow_q      <= cfg_data;
					tpdc_pkg::REG_TARGET:    target_q    <= cfg_data[tpdc_pkg::MOIST_W-1:0];
					tpdc_pkg::REG_AUTO_DUR:  auto_dur_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pump_drive_q <= dose_d.phase;
			watering_q   <= dose_d.busy;
			done_res_q   <= res_done;
			done_dur_q   <= res_dur;
			error_q      <= res_err;
		end
	end

	assign out_valid        = out_valid_q;
	assign pump_drive       = pump_drive_q;
	assign watering         = watering_q;
	assign done_res         = done_res_q;
	assign done_duration_ms = done_dur_q;
	assign error            = error_q;

endmodule

### hw/rtl/tpdc_checker.sv
`include "timed_pump_dose_controller_assert.svh"

module tpdc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  pump_drive,
	input logic                        watering,
	input logic                        done_res,
	input logic [tpdc_pkg::DUR_W-1:0]  done_duration_ms,
	input logic [1:0]                  error
);

	`TPDC_ASSERT_IMP(a_drive_needs_dose, out_valid && pump_drive != tpdc_pkg::DRIVE_OFF, watering, "pump driven with no dose in progress")

	`TPDC_ASSERT_IMP(a_dose_drives_pump, out_valid && watering, pump_drive == tpdc_pkg::DRIVE_KICK || pump_drive == tpdc_pkg::DRIVE_RUN, "dose in progress with pump off")

	`TPDC_ASSERT_IMP(a_done_ends_dose, out_valid && done_res, !watering && error == tpdc_pkg::ERR_NONE, "done report with dose still running or error")

	`TPDC_ASSERT_IMP(a_dur_only_on_done, out_valid && !done_res, done_duration_ms == '0, "duration reported without done")

	`TPDC_ASSERT_NEXT(a_stalled_holds, out_valid && out_stall, out_valid && $stable(pump_drive) && $stable(done_duration_ms), "stalled transaction changed")

endmodule

bind timed_pump_dose_controller tpdc_checker u_tpdc_checker (.*);
